// ----- hdl/fsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, codes and defaults of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int MEM_SLOTS_DEF      = 64;
    localparam int MAX_UNITS_DEF      = 16;
    localparam int UNIT_TAG_RADIX_DEF = 100;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LEN = 2'd1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] owner_id;
        logic [4:0] unit_count;
        logic [6:0] unit_length;
    } fsa_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] unit_number;
        logic [5:0] base_slot;
        logic [6:0] slots_freed;
        logic [6:0] free_after;
        logic       last;
    } fsa_rsp_t;

    typedef struct packed {
        logic [7:0] owner;
        logic [4:0] unit;
    } slot_entry_t;

endpackage

// ----- hdl/fsa_slot_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_slot_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsa_slot_mem
    import fsa_pkg::*;
#(
    parameter int DEPTH = MEM_SLOTS_DEF,
    parameter int AW    = $clog2(MEM_SLOTS_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  slot_entry_t       wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output slot_entry_t       rdata
);

    slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/first_fit_slot_allocator.sv -----
`timescale 1ns / 1ps
// Sequence: allocate scans the slot store once, then writes back each unit's slots
//   with one result per unit; release scans the slot store once, then answers;
//   an allocate rejected on its fields alone answers without a scan.
// Throughput: one item at a time, set by the sweep over the slot store.
// Reset: async active low; afterwards a clearing pass writes every slot free,
//   during which no item is taken (configuration still is).
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit allocator of contiguous slot runs in paging or segmentation mode.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator
    import fsa_pkg::*;
#(
    parameter int MEM_SLOTS      = MEM_SLOTS_DEF,
    parameter int MAX_UNITS      = MAX_UNITS_DEF,
    parameter int UNIT_TAG_RADIX = UNIT_TAG_RADIX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fsa_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output fsa_rsp_t              rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MEM_SLOTS);
    localparam int CW = $clog2(MEM_SLOTS + 1);
    localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MEM_SLOTS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          mode_reg;
    logic [6:0]    plen_reg;
    fsa_req_t      item_reg, item_next;
    logic [6:0]    len_reg, len_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic [6:0]    run_reg, run_next;
    logic [4:0]    found_reg, found_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] freed_reg, freed_next;
    logic [CW-1:0] free_reg, free_next;
    logic [4:0]    cu_reg, cu_next;
    logic [6:0]    wo_reg, wo_next;
    fsa_rsp_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;
    fsa_rsp_t      hold_reg, hold_next;
    logic [AW-1:0] base_arr [MAX_UNITS];

    logic          base_we;
    logic [AW-1:0] base_wval;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    slot_entry_t   mem_wdata, mem_rdata;
    logic          out_free;
    logic [6:0]    req_len;
    logic          req_bad;
    logic [AW-1:0] cur_base;

    fsa_slot_mem #(
        .DEPTH (MEM_SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cur_base  = base_arr[IW'(cu_reg)];

    assign req_len = mode_reg ? plen_reg : req.unit_length;
    assign req_bad = (req.owner_id == 8'd0) || (req.unit_count == 5'd0)
                  || (32'(req.unit_count) > 32'(MAX_UNITS))
                  || (32'(req.unit_count) >= 32'(UNIT_TAG_RADIX))
                  || (req_len == 7'd0) || (32'(req_len) > 32'(MEM_SLOTS));

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        iss_next       = iss_reg;
        pend_next      = 1'b0;
        paddr_next     = paddr_reg;
        run_next       = run_reg;
        found_next     = found_reg;
        total_next     = total_reg;
        freed_next     = freed_reg;
        free_next      = free_reg;
        cu_next        = cu_reg;
        wo_next        = wo_reg;
        hold_next      = hold_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = '0;
        base_we        = 1'b0;
        base_wval      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_SLOT)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    len_next   = req_len;
                    ptr_next   = '0;
                    iss_next   = 1'b1;
                    run_next   = '0;
                    found_next = '0;
                    total_next = '0;
                    freed_next = '0;
                    state_next = S_SCAN;
                    if (req.operation == OP_ALLOC && req_bad)
                    begin
                        hold_next  = '{ST_REJECTED, 5'd0, 6'd0, 7'd0, 7'(free_reg), 1'b1};
                        state_next = S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                // issue reads one slot ahead of processing
                if (iss_reg)
                begin
                    mem_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == LAST_SLOT)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (item_reg.operation == OP_RELEASE)
                    begin
                        if (item_reg.owner_id != 8'd0 && mem_rdata.owner == item_reg.owner_id)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = paddr_reg;
                            freed_next = freed_reg + 1'b1;
                        end
                        if (paddr_reg == LAST_SLOT)
                        begin
                            free_next  = free_reg + freed_next;
                            hold_next  = '{ST_RELEASED, 5'd0, 6'd0, 7'(freed_next),
                                           7'(free_reg + freed_next), 1'b1};
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        // a placed run restarts the run count, so one sweep finds all units
                        if (found_reg != item_reg.unit_count)
                        begin
                            if (mem_rdata.owner != 8'd0)
                            begin
                                run_next = '0;
                            end
                            else if (7'(run_reg + 1'b1) == len_reg)
                            begin
                                base_we    = 1'b1;
                                base_wval  = AW'(32'(paddr_reg) + 32'd1 - 32'(len_reg));
                                found_next = found_reg + 1'b1;
                                total_next = CW'(32'(total_reg) + 32'(len_reg));
                                run_next   = '0;
                            end
                            else
                            begin
                                run_next = run_reg + 1'b1;
                            end
                        end
                        if (paddr_reg == LAST_SLOT)
                        begin
                            if (found_next == item_reg.unit_count)
                            begin
                                free_next  = free_reg - total_next;
                                cu_next    = '0;
                                wo_next    = '0;
                                state_next = S_COMMIT;
                            end
                            else
                            begin
                                hold_next  = '{ST_REJECTED, 5'd0, 6'd0, 7'd0,
                                               7'(free_reg), 1'b1};
                                state_next = S_EMIT;
                            end
                        end
                    end
                end
            end
            S_COMMIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(32'(cur_base) + 32'(wo_reg));
                mem_wdata = '{item_reg.owner_id, 5'(cu_reg + 1'b1)};
                if (7'(wo_reg + 1'b1) == len_reg)
                begin
                    // hold on the unit's last slot until the output register frees
                    if (out_free)
                    begin
                        rsp_next       = '{ST_PLACED, 5'(cu_reg + 1'b1), 6'(cur_base), 7'd0,
                                           7'(free_reg),
                                           (5'(cu_reg + 1'b1) == item_reg.unit_count)};
                        rsp_valid_next = 1'b1;
                        wo_next        = '0;
                        cu_next        = cu_reg + 1'b1;
                        if (5'(cu_reg + 1'b1) == item_reg.unit_count)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    wo_next = wo_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= 1'b1;
            plen_reg      <= 7'd4;
            ptr_reg       <= '0;
            iss_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            free_reg      <= CW'(MEM_SLOTS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MODE:     mode_reg <= cfg_data[0];
                    CFG_PAGE_LEN: plen_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        len_reg   <= len_next;
        paddr_reg <= paddr_next;
        run_reg   <= run_next;
        found_reg <= found_next;
        total_reg <= total_next;
        freed_reg <= freed_next;
        cu_reg    <= cu_next;
        wo_reg    <= wo_next;
        hold_reg  <= hold_next;
        rsp_reg   <= rsp_next;
        if (base_we)
        begin
            base_arr[IW'(found_reg)] <= base_wval;
        end
    end

endmodule

// ----- hdl/fsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the first-fit slot allocator.
// ----------------------------------------------------------------------------
module fsa_checker
    import fsa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input fsa_rsp_t rsp
);

    // hold a pending result until its transaction completes
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_PLACED || rsp.status == ST_REJECTED
                   || rsp.status == ST_RELEASED)
        else $error("bad status code");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_PLACED |-> rsp.last && rsp.unit_number == 5'd0)
        else $error("reject or release result not final");

endmodule

bind first_fit_slot_allocator fsa_checker u_fsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
